FILE: hw/rtl/quaternion_pose_to_view_matrix_assert.svh
// Assertion macros for the pose to view matrix block.
`ifndef QUATERNION_POSE_TO_VIEW_MATRIX_ASSERT_SVH
`define QUATERNION_POSE_TO_VIEW_MATRIX_ASSERT_SVH

`ifndef ASSERT_OFF

`define QPV_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

`define QPV_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`else

`define QPV_ASSERT_IMPL(label, clk, rst_n, cond, prop)

`define QPV_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: hw/rtl/qpv_pkg.sv
// Types, widths and rounding functions shared by the pose to view matrix block.
package qpv_pkg;

    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int POS_WIDTH      = 24;

    // Rotation path widths.
    localparam int QPROD_W   = 2 * QUAT_WIDTH;
    localparam int ROT_SUM_W = QPROD_W + 2;
    localparam int ROT_RND_W = ROT_SUM_W - QUAT_FRAC_BITS + 1;

    // Translation path widths.
    localparam int PPROD_W = QUAT_WIDTH + POS_WIDTH;
    localparam int ACC_W   = PPROD_W + 2;
    localparam int NEG_W   = ACC_W + 1;
    localparam int TR_W    = NEG_W + 1 - QUAT_FRAC_BITS;

    typedef logic signed [QUAT_WIDTH-1:0] quat_t;
    typedef logic signed [POS_WIDTH-1:0]  pos_t;

    localparam logic signed [ROT_SUM_W-1:0] ROT_ONE2 =
        ROT_SUM_W'(1) <<< (2 * QUAT_FRAC_BITS);
    localparam logic signed [ROT_SUM_W:0] ROT_HALF =
        (ROT_SUM_W + 1)'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [ROT_RND_W-1:0] ROT_MAX = ROT_RND_W'(1) <<< QUAT_FRAC_BITS;
    localparam logic signed [ROT_RND_W-1:0] ROT_MIN = -ROT_MAX;
    localparam quat_t QUAT_ONE = QUAT_WIDTH'(ROT_MAX);

    localparam logic signed [NEG_W:0] TR_HALF = (NEG_W + 1)'(1) <<< (QUAT_FRAC_BITS - 1);
    localparam logic signed [TR_W-1:0] POS_MAX = (TR_W'(1) <<< (POS_WIDTH - 1)) - TR_W'(1);
    localparam logic signed [TR_W-1:0] POS_MIN = -(TR_W'(1) <<< (POS_WIDTH - 1));

    typedef struct packed {
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        quat_t quat_w;
        pos_t  pos_x;
        pos_t  pos_y;
        pos_t  pos_z;
    } pose_t;

    typedef struct packed {
        quat_t view_00;
        quat_t view_01;
        quat_t view_02;
        pos_t  view_03;
        quat_t view_10;
        quat_t view_11;
        quat_t view_12;
        pos_t  view_13;
        quat_t view_20;
        quat_t view_21;
        quat_t view_22;
        pos_t  view_23;
    } view_t;

    // Rounds a rotation term from 2F to F fraction bits, ties upward, then clamps to +/-1.0.
    function automatic quat_t rot_round(input logic signed [ROT_SUM_W-1:0] v);
        logic signed [ROT_SUM_W:0] a;
        logic signed [ROT_RND_W-1:0] r;
        a = (ROT_SUM_W + 1)'(v) + ROT_HALF;
        r = a[ROT_SUM_W:QUAT_FRAC_BITS];
        if (r > ROT_MAX)
        begin
            r = ROT_MAX;
        end
        else if (r < ROT_MIN)
        begin
            r = ROT_MIN;
        end
        return QUAT_WIDTH'(r);
    endfunction

    // Negates the dot product, rounds off F fraction bits and saturates to the position range.
    function automatic pos_t pos_round(input logic signed [ACC_W-1:0] acc);
        logic signed [NEG_W-1:0] n;
        logic signed [NEG_W:0] a;
        logic signed [TR_W-1:0] r;
        n = -NEG_W'(acc);
        a = (NEG_W + 1)'(n) + TR_HALF;
        r = a[NEG_W:QUAT_FRAC_BITS];
        if (r > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (r < POS_MIN)
        begin
            r = POS_MIN;
        end
        return POS_WIDTH'(r);
    endfunction

endpackage

FILE: hw/rtl/qpv_pose_if.sv
// Valid/ready channel that carries one camera pose per beat.
interface qpv_pose_if import qpv_pkg::*; ();
    logic  valid;
    logic  ready;
    pose_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/qpv_view_if.sv
// Valid/ready channel that carries one 3x4 view matrix per beat.
interface qpv_view_if import qpv_pkg::*; ();
    logic  valid;
    logic  ready;
    view_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/quaternion_pose_to_view_matrix.sv
// Pose to view matrix: six-stage pipeline from quaternion and position to [R^T | -R^T p].
// Throughput: one pose per cycle; each stage holds when the stage after it is full and stalled.
// A stalled output register still lets earlier stages fill their empty slots.
// Reset clears only the stage valid bits; data registers are not reset.
`include "quaternion_pose_to_view_matrix_assert.svh"

module quaternion_pose_to_view_matrix
    import qpv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    qpv_pose_if.sink          pose,
    qpv_view_if.source        view
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    // Stage 1: the nine quaternion products.
    logic signed [QPROD_W-1:0] q_xx_reg, q_yy_reg, q_zz_reg;
    logic signed [QPROD_W-1:0] q_xy_reg, q_xz_reg, q_yz_reg;
    logic signed [QPROD_W-1:0] q_wx_reg, q_wy_reg, q_wz_reg;
    pos_t p1_reg [3];

    // Stage 2: rotation terms at 2F fraction bits, indexed as view rows.
    logic signed [ROT_SUM_W-1:0] rsum_reg [3][3];
    pos_t p2_reg [3];

    // Stage 3: rounded and saturated rotation entries.
    quat_t rot3_reg [3][3];
    pos_t  p3_reg [3];

    // Stage 4: rotation times position products.
    logic signed [PPROD_W-1:0] tp_reg [3][3];
    quat_t rot4_reg [3][3];

    // Stage 5: dot products.
    logic signed [ACC_W-1:0] acc_reg [3];
    quat_t rot5_reg [3][3];

    // Stage 6: output register.
    view_t view_reg;
    view_t view_next;

    logic diag_ok;

    quat_t qx, qy, qz, qw;

    assign qx = pose.data.quat_x;
    assign qy = pose.data.quat_y;
    assign qz = pose.data.quat_z;
    assign qw = pose.data.quat_w;

    // A stage may load when it is empty or when its contents move on this cycle.
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || view.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign pose.ready = en[0];
    assign view.valid = valid_reg[NSTAGE-1];
    assign view.data  = view_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= pose.valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_xx_reg <= QPROD_W'(qx) * QPROD_W'(qx);
            q_yy_reg <= QPROD_W'(qy) * QPROD_W'(qy);
            q_zz_reg <= QPROD_W'(qz) * QPROD_W'(qz);
            q_xy_reg <= QPROD_W'(qx) * QPROD_W'(qy);
            q_xz_reg <= QPROD_W'(qx) * QPROD_W'(qz);
            q_yz_reg <= QPROD_W'(qy) * QPROD_W'(qz);
            q_wx_reg <= QPROD_W'(qw) * QPROD_W'(qx);
            q_wy_reg <= QPROD_W'(qw) * QPROD_W'(qy);
            q_wz_reg <= QPROD_W'(qw) * QPROD_W'(qz);
            p1_reg[0] <= pose.data.pos_x;
            p1_reg[1] <= pose.data.pos_y;
            p1_reg[2] <= pose.data.pos_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rsum_reg[0][0] <= ROT_ONE2
                - ((ROT_SUM_W'(q_yy_reg) + ROT_SUM_W'(q_zz_reg)) <<< 1);
            rsum_reg[1][1] <= ROT_ONE2
                - ((ROT_SUM_W'(q_xx_reg) + ROT_SUM_W'(q_zz_reg)) <<< 1);
            rsum_reg[2][2] <= ROT_ONE2
                - ((ROT_SUM_W'(q_xx_reg) + ROT_SUM_W'(q_yy_reg)) <<< 1);
            rsum_reg[1][0] <= (ROT_SUM_W'(q_xy_reg) - ROT_SUM_W'(q_wz_reg)) <<< 1;
            rsum_reg[2][0] <= (ROT_SUM_W'(q_xz_reg) + ROT_SUM_W'(q_wy_reg)) <<< 1;
            rsum_reg[0][1] <= (ROT_SUM_W'(q_xy_reg) + ROT_SUM_W'(q_wz_reg)) <<< 1;
            rsum_reg[2][1] <= (ROT_SUM_W'(q_yz_reg) - ROT_SUM_W'(q_wx_reg)) <<< 1;
            rsum_reg[0][2] <= (ROT_SUM_W'(q_xz_reg) - ROT_SUM_W'(q_wy_reg)) <<< 1;
            rsum_reg[1][2] <= (ROT_SUM_W'(q_yz_reg) + ROT_SUM_W'(q_wx_reg)) <<< 1;
            p2_reg <= p1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rot3_reg[i][j] <= rot_round(rsum_reg[i][j]);
                end
            end
            p3_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    tp_reg[i][j] <= PPROD_W'(rot3_reg[i][j]) * PPROD_W'(p3_reg[j]);
                end
            end
            rot4_reg <= rot3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= ACC_W'(tp_reg[i][0]) + ACC_W'(tp_reg[i][1])
                    + ACC_W'(tp_reg[i][2]);
            end
            rot5_reg <= rot4_reg;
        end
    end

    always_comb
    begin
        view_next.view_00 = rot5_reg[0][0];
        view_next.view_01 = rot5_reg[0][1];
        view_next.view_02 = rot5_reg[0][2];
        view_next.view_03 = pos_round(acc_reg[0]);
        view_next.view_10 = rot5_reg[1][0];
        view_next.view_11 = rot5_reg[1][1];
        view_next.view_12 = rot5_reg[1][2];
        view_next.view_13 = pos_round(acc_reg[1]);
        view_next.view_20 = rot5_reg[2][0];
        view_next.view_21 = rot5_reg[2][1];
        view_next.view_22 = rot5_reg[2][2];
        view_next.view_23 = pos_round(acc_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE-1])
        begin
            view_reg <= view_next;
        end
    end

    assign diag_ok = (view_reg.view_00 <= QUAT_ONE) && (view_reg.view_00 >= -QUAT_ONE)
        && (view_reg.view_11 <= QUAT_ONE) && (view_reg.view_11 >= -QUAT_ONE)
        && (view_reg.view_22 <= QUAT_ONE) && (view_reg.view_22 >= -QUAT_ONE);

    // With the output register empty the whole pipeline can load.
    `QPV_ASSERT_IMPL(a_ready_when_out_empty, clk, rst_n, !valid_reg[NSTAGE-1], pose.ready)
    // A beat that leaves the first stage must land in the second.
    `QPV_ASSERT_NEXT(a_stage_advance, clk, rst_n, valid_reg[0] && en[1], valid_reg[1])
    // Diagonal entries must stay within the saturation range.
    `QPV_ASSERT_IMPL(a_diag_range, clk, rst_n, view.valid, diag_ok)

endmodule
